@@ sv/rrq_pkg.sv @@
// ----------------------------------------------------------------------------
// Reversible record queue package
// Shared widths, command and status codes for the record queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

	// Default queue depth in records.
	localparam int DEPTH_DEF = 64;

	// Field widths of one word.
	localparam int CMD_W   = 3;
	localparam int CODE_W  = 16;
	localparam int LABEL_W = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;
	localparam int REC_W   = CODE_W + LABEL_W;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP     = 3'd1,
		CMD_FIRST   = 3'd2,
		CMD_LAST    = 3'd3,
		CMD_REVERSE = 3'd4
	} cmd_t;

	// Status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_FEW   = 2'd3
	} status_t;

	// One stored record: code in the upper bits, label in the lower bits.
	typedef logic [REC_W-1:0] rec_t;

endpackage

@@ sv/reversible_record_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Reversible record queue unit
// Bounded record queue with push at the front, pop at the tail, peeks at
// both ends and an in-place order reversal.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every command
// gives exactly one result word. Done is high for the single cycle that the
// sequencer spends in its response state, up to the rising edge that ends
// that state. The receiver cannot stall it and must capture the word at that
// edge. A new command is accepted only after the previous one has passed
// through the shared ring-address adder, the single memory port, a state
// that presents the result, and an idle state in which busy is low and the
// next command is taken. Reverse takes the same steps at any fill, since it
// only moves the front pointer to the tail and flips the ring direction. The
// storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module reversible_record_queue_unit #(
	parameter int DEPTH = rrq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rrq_pkg::CMD_W-1:0]         command,
	input  logic signed [rrq_pkg::CODE_W-1:0] code,
	input  logic [rrq_pkg::LABEL_W-1:0]       label,
	output logic                              done,
	output logic [rrq_pkg::STAT_W-1:0]        status,
	output logic signed [rrq_pkg::CODE_W-1:0] code_out,
	output logic [rrq_pkg::LABEL_W-1:0]       label_out,
	output logic [rrq_pkg::COUNT_W-1:0]       count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_ACC  = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [AW-1:0]       head_q;
	logic                dir_q;
	logic [AW-1:0]       addr_q;
	logic [rrq_pkg::CMD_W-1:0] cmd_q;
	rrq_pkg::rec_t       rec_q;
	rrq_pkg::status_t    status_q;
	logic                go_q;
	logic                rd_q;

	logic [AW-1:0]       unit_offset;
	logic                unit_sub;
	logic [AW-1:0]       unit_addr;
	logic [AW-1:0]       tail_off;
	logic                is_empty;
	logic                is_full;
	logic                is_few;
	rrq_pkg::status_t    status_d;
	logic                go_d;
	logic                mem_we;
	logic                mem_re;
	rrq_pkg::rec_t       mem_rdata;

	// Fill conditions.
	assign is_empty = (fill_q == '0);
	assign is_full  = (fill_q == CW'(DEPTH));
	assign is_few   = (fill_q < CW'(2));
	assign tail_off = AW'(fill_q - CW'(1));

	// Operand selection for the shared adder and the command's status.
	always_comb begin
		unit_offset = tail_off;
		unit_sub    = dir_q;
		status_d    = rrq_pkg::ST_OK;
		go_d        = 1'b0;
		case (cmd_q)
			rrq_pkg::CMD_PUSH: begin
				unit_offset = AW'(1);
				unit_sub    = ~dir_q;
				status_d    = is_full ? rrq_pkg::ST_FULL : rrq_pkg::ST_OK;
				go_d        = ~is_full;
			end
			rrq_pkg::CMD_POP, rrq_pkg::CMD_LAST: begin
				status_d = is_empty ? rrq_pkg::ST_EMPTY : rrq_pkg::ST_OK;
				go_d     = ~is_empty;
			end
			rrq_pkg::CMD_FIRST: begin
				unit_offset = '0;
				status_d    = is_empty ? rrq_pkg::ST_EMPTY : rrq_pkg::ST_OK;
				go_d        = ~is_empty;
			end
			rrq_pkg::CMD_REVERSE: begin
				status_d = is_few ? rrq_pkg::ST_FEW : rrq_pkg::ST_OK;
				go_d     = ~is_few;
			end
			default: begin
				status_d = rrq_pkg::ST_OK;
				go_d     = 1'b0;
			end
		endcase
	end

	rrq_addr_unit #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_addr (
		.base   (head_q),
		.offset (unit_offset),
		.sub    (unit_sub),
		.addr   (unit_addr)
	);

	// Memory access happens in the access state only.
	assign mem_we = (state_q == S_ACC) && go_q && (cmd_q == rrq_pkg::CMD_PUSH);
	assign mem_re = (state_q == S_ACC) && go_q &&
		(cmd_q inside {rrq_pkg::CMD_POP, rrq_pkg::CMD_FIRST, rrq_pkg::CMD_LAST});

	rrq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (addr_q),
		.wdata (rec_q),
		.rdata (mem_rdata)
	);

	// Command word capture, then address and status capture in the calculate state.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			cmd_q <= command;
			rec_q <= {code, label};
		end
		if (state_q == S_CALC) begin
			addr_q   <= unit_addr;
			status_q <= status_d;
		end
	end

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			head_q  <= '0;
			dir_q   <= 1'b0;
			go_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					go_q    <= go_d;
					state_q <= S_ACC;
				end
				S_ACC: begin
					rd_q <= mem_re;
					if (go_q) begin
						case (cmd_q)
							rrq_pkg::CMD_PUSH: begin
								head_q <= addr_q;
								fill_q <= fill_q + CW'(1);
							end
							rrq_pkg::CMD_POP: begin
								fill_q <= fill_q - CW'(1);
							end
							rrq_pkg::CMD_REVERSE: begin
								head_q <= addr_q;
								dir_q  <= ~dir_q;
							end
							default: begin
							end
						endcase
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word.
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_RESP);
	assign status    = status_q;
	assign code_out  = rd_q ? mem_rdata[rrq_pkg::REC_W-1:rrq_pkg::LABEL_W] : '0;
	assign label_out = rd_q ? mem_rdata[rrq_pkg::LABEL_W-1:0] : '0;
	assign count     = rrq_pkg::COUNT_W'(fill_q);

endmodule

@@ sv/rrq_addr_unit.sv @@
// ----------------------------------------------------------------------------
// Record queue address unit
// Shared ring-address adder: (base + offset) or (base - offset) modulo DEPTH.
// ----------------------------------------------------------------------------
module rrq_addr_unit #(
	parameter int DEPTH = rrq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic [AW-1:0] base,
	input  logic [AW-1:0] offset,
	input  logic          sub,
	output logic [AW-1:0] addr
);

	logic [AW:0] sum;
	logic [AW:0] diff;

	// Both operands are below DEPTH, so one correction step wraps the result.
	always_comb begin
		sum  = {1'b0, base} + {1'b0, offset};
		diff = {1'b0, base} - {1'b0, offset};
		if (sub) begin
			if (base < offset) begin
				addr = AW'(diff + (AW+1)'(DEPTH));
			end else begin
				addr = diff[AW-1:0];
			end
		end else begin
			if (sum >= (AW+1)'(DEPTH)) begin
				addr = AW'(sum - (AW+1)'(DEPTH));
			end else begin
				addr = sum[AW-1:0];
			end
		end
	end

endmodule

@@ sv/rrq_mem.sv @@
// ----------------------------------------------------------------------------
// Record queue storage
// Single-port record memory with a registered read.
// ----------------------------------------------------------------------------
module rrq_mem #(
	parameter int DEPTH = rrq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  rrq_pkg::rec_t wdata,
	output rrq_pkg::rec_t rdata
);

	rrq_pkg::rec_t mem_q [DEPTH];
	rrq_pkg::rec_t rdata_q;

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ bench/reversible_record_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reversible record queue unit testbench
// Drives push, pop, peek, reverse and spare command words into the queue.
// A tracking class keeps its own copy of the stored records and checks every
// result word field by field. A short directed run covers the empty, single
// entry and spare-code cases. Random phases then alternate between filling
// and draining the queue, so the full and empty limits are hit again and
// again, with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module reversible_record_queue_unit_tb;

	typedef logic [rrq_pkg::CMD_W-1:0]          cmd_bits_t;
	typedef logic signed [rrq_pkg::CODE_W-1:0]  code_bits_t;
	typedef logic [rrq_pkg::LABEL_W-1:0]        label_bits_t;
	typedef logic [rrq_pkg::STAT_W-1:0]         stat_bits_t;
	typedef logic [rrq_pkg::COUNT_W-1:0]        count_bits_t;

	localparam int DEPTH       = rrq_pkg::DEPTH_DEF;
	localparam int CMD_CODES   = 1 << rrq_pkg::CMD_W;
	localparam int PHASES      = 10;
	localparam int PHASE_LEN   = 150;
	localparam int IDLE_PCT    = 23;
	localparam int CYCLE_LIMIT = 200000;

	localparam cmd_bits_t CMD_SPARE_LO = cmd_bits_t'(rrq_pkg::CMD_REVERSE + 1);
	localparam cmd_bits_t CMD_SPARE_HI = cmd_bits_t'(CMD_CODES - 1);

	localparam code_bits_t CODE_MIN = {1'b1, {(rrq_pkg::CODE_W-1){1'b0}}};
	localparam code_bits_t CODE_MAX = ~CODE_MIN;

	// One expected result word.
	typedef struct {
		rrq_pkg::status_t  st;
		code_bits_t        code;
		label_bits_t       lab;
		count_bits_t       fill;
	} queue_result_t;

	// Tracks the queue contents and the result words still to come.
	class record_queue_tracker_t;
		rrq_pkg::rec_t held[$];
		queue_result_t awaited[$];
		int            failures;

		// Applies one accepted command word to the tracked queue.
		function void note_command(cmd_bits_t cmd, code_bits_t c, label_bits_t l);
			queue_result_t r;
			rrq_pkg::rec_t flipped[$];
			rrq_pkg::rec_t pick;
			r.st   = rrq_pkg::ST_OK;
			r.code = '0;
			r.lab  = '0;
			case (cmd)
			rrq_pkg::CMD_PUSH: begin
				if (held.size() >= DEPTH)
					r.st = rrq_pkg::ST_FULL;
				else
					held.push_front({c, l});
			end
			rrq_pkg::CMD_POP, rrq_pkg::CMD_FIRST, rrq_pkg::CMD_LAST: begin
				if (held.size() == 0) begin
					r.st = rrq_pkg::ST_EMPTY;
				end else begin
					pick = (cmd == rrq_pkg::CMD_FIRST) ? held[0] : held[held.size() - 1];
					if (cmd == rrq_pkg::CMD_POP)
						void'(held.pop_back());
					{r.code, r.lab} = pick;
				end
			end
			rrq_pkg::CMD_REVERSE: begin
				if (held.size() < 2) begin
					r.st = rrq_pkg::ST_FEW;
				end else begin
					foreach (held[i])
						flipped.push_front(held[i]);
					held = flipped;
				end
			end
			default: ;
			endcase
			r.fill = count_bits_t'(held.size());
			awaited.push_back(r);
		endfunction

		// Compares one result word with the oldest expectation.
		function void check_word(stat_bits_t st, code_bits_t c, label_bits_t l,
				count_bits_t n);
			queue_result_t exp_r;
			if (awaited.size() == 0) begin
				$error("result word with no command outstanding");
				failures++;
				return;
			end
			exp_r = awaited.pop_front();
			if (st !== exp_r.st) begin
				$error("status: expected %0d, actual %0d", exp_r.st, st);
				failures++;
			end
			if (c !== exp_r.code) begin
				$error("code_out: expected %0d, actual %0d", exp_r.code, c);
				failures++;
			end
			if (l !== exp_r.lab) begin
				$error("label_out: expected %0d, actual %0d", exp_r.lab, l);
				failures++;
			end
			if (n !== exp_r.fill) begin
				$error("count: expected %0d, actual %0d", exp_r.fill, n);
				failures++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	cmd_bits_t                  command;
	code_bits_t                 code;
	label_bits_t                label;
	logic                       done;
	stat_bits_t                 status;
	code_bits_t                 code_out;
	label_bits_t                label_out;
	count_bits_t                count;
	int                         cycles = 0;

	record_queue_tracker_t sb = new();

	reversible_record_queue_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.code(code),
		.label(label),
		.done(done),
		.status(status),
		.code_out(code_out),
		.label_out(label_out),
		.count(count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result words are captured in the single cycle they are shown.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_word(status, code_out, label_out, count);
	end

	// Presents one command word, waits for it to be taken and may then idle.
	task automatic issue_word(input cmd_bits_t cmd, input code_bits_t c,
			input label_bits_t l, input int idle_pct);
		start   <= 1'b1;
		command <= cmd;
		code    <= c;
		label   <= l;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(cmd, c, l);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Holds off new commands until every outstanding result word is back.
	task automatic drain_results();
		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random command word; push_pct sets how hard the queue is filled.
	task automatic random_word(input int push_pct, input int idle_pct);
		cmd_bits_t  cmd;
		code_bits_t c;
		int         pick;
		pick = $urandom_range(99);
		if (pick < push_pct) begin
			cmd = rrq_pkg::CMD_PUSH;
		end else begin
			pick = $urandom_range(99);
			if (pick < 45)
				cmd = rrq_pkg::CMD_POP;
			else if (pick < 60)
				cmd = rrq_pkg::CMD_FIRST;
			else if (pick < 75)
				cmd = rrq_pkg::CMD_LAST;
			else if (pick < 95)
				cmd = rrq_pkg::CMD_REVERSE;
			else
				cmd = cmd_bits_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		c = code_bits_t'($urandom);
		if ($urandom_range(9) == 0)
			c = $urandom_range(1) ? CODE_MAX : CODE_MIN;
		issue_word(cmd, c, label_bits_t'($urandom), idle_pct);
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		command = rrq_pkg::CMD_PUSH;
		code    = '0;
		label   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, a single entry, both code extremes, spare codes.
		issue_word(rrq_pkg::CMD_POP, CODE_MAX, 8'hFF, IDLE_PCT);
		issue_word(rrq_pkg::CMD_FIRST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_LAST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_REVERSE, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_PUSH, CODE_MIN, 8'h00, IDLE_PCT);
		issue_word(rrq_pkg::CMD_REVERSE, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_FIRST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_LAST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_PUSH, CODE_MAX, 8'hFF, IDLE_PCT);
		issue_word(rrq_pkg::CMD_PUSH, '0, 8'hA5, IDLE_PCT);
		issue_word(rrq_pkg::CMD_REVERSE, CODE_MIN, 8'h5A, IDLE_PCT);
		issue_word(rrq_pkg::CMD_FIRST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_LAST, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_POP, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_POP, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_POP, '0, '0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_POP, '0, '0, IDLE_PCT);
		issue_word(CMD_SPARE_LO, CODE_MAX, 8'hFF, IDLE_PCT);
		issue_word(cmd_bits_t'(CMD_SPARE_LO + 1), CODE_MIN, 8'h0F, IDLE_PCT);
		issue_word(CMD_SPARE_HI, '1, 8'hF0, IDLE_PCT);
		issue_word(rrq_pkg::CMD_PUSH, -16'sd1, 8'h5A, IDLE_PCT);
		issue_word(rrq_pkg::CMD_FIRST, '0, '0, IDLE_PCT);
		drain_results();

		// Random: even phases fill the queue up to full, odd phases drain it.
		for (int p = 0; p < PHASES; p++) begin
			for (int k = 0; k < PHASE_LEN; k++)
				random_word((p % 2 == 0) ? 70 : 5, (p == 4) ? 0 : IDLE_PCT);
			if (p % 3 == 2)
				drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
